[rtl/core/hed_pkg.sv]
// shared types, constants and entity table for the html entity decoder
package hed_pkg;

    // number of held bytes after an open ampersand (longest entity body minus its semicolon)
    localparam int HeldMax   = 5;
    localparam int NumEnt    = 8;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    // character codes
    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChLt   = 8'h3C;
    localparam logic [7:0] ChGt   = 8'h3E;
    localparam logic [7:0] ChQuot = 8'h22;
    localparam logic [7:0] ChApos = 8'h27;
    localparam logic [7:0] ChDash = 8'h2D;

    // one queue entry: either a single byte or a flush of '&', held bytes and an optional extra byte
    typedef struct packed {
        logic                     last;
        logic                     flush;
        logic [2:0]               held_cnt;
        logic                     extra_vld;
        logic [7:0]               byte_val;
        logic [HeldMax-1:0][7:0]  held;
    } entry_t;

    // entity body after the '&', first character in the low byte
    function automatic logic [47:0] ent_body(input logic [2:0] k);
        case (k)
            3'd0:    return {16'h0, ";", "p", "m", "a"};
            3'd1:    return {24'h0, ";", "t", "l"};
            3'd2:    return {24'h0, ";", "t", "g"};
            3'd3:    return {8'h0, ";", "t", "o", "u", "q"};
            3'd4:    return {16'h0, ";", "9", "3", "#"};
            3'd5:    return {8'h0, ";", "s", "o", "p", "a"};
            3'd6:    return {";", "h", "s", "a", "d", "n"};
            3'd7:    return {";", "h", "s", "a", "d", "m"};
            default: return 48'h0;
        endcase
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] pos);
        logic [47:0] body;
        body = ent_body(k);
        case (pos)
            3'd0:    return body[7:0];
            3'd1:    return body[15:8];
            3'd2:    return body[23:16];
            3'd3:    return body[31:24];
            3'd4:    return body[39:32];
            3'd5:    return body[47:40];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] k);
        case (k)
            3'd0, 3'd4:       return 3'd4;
            3'd1, 3'd2:       return 3'd3;
            3'd3, 3'd5:       return 3'd5;
            3'd6, 3'd7:       return 3'd6;
            default:          return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] ent_repl(input logic [2:0] k);
        case (k)
            3'd0:       return ChAmp;
            3'd1:       return ChLt;
            3'd2:       return ChGt;
            3'd3:       return ChQuot;
            3'd4, 3'd5: return ChApos;
            3'd6, 3'd7: return ChDash;
            default:    return 8'h00;
        endcase
    endfunction

endpackage

[rtl/core/hed_front.sv]
// front end: accepts input items, tracks open entities and classifies the results
module hed_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_vld,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             q_full,
    output logic             in_rdy,
    output logic             q_push,
    output hed_pkg::entry_t  q_entry
);

    logic                                  amp_open_reg, amp_open_next;
    logic [2:0]                            held_cnt_reg, held_cnt_next;
    logic [hed_pkg::NumEnt-1:0]            cand_reg, cand_next;
    logic [hed_pkg::HeldMax-1:0][7:0]      held_reg;

    logic [hed_pkg::NumEnt-1:0]            hit;
    logic [hed_pkg::NumEnt-1:0]            complete;
    logic                                  done_any;
    logic                                  prefix_any;
    logic [7:0]                            repl;
    logic                                  hold_wr;
    logic                                  emit;
    logic                                  accept;

    assign in_rdy = !q_full;
    assign accept = in_vld && in_rdy;

    // compare the new byte against every entity still in the running
    always_comb begin
        done_any = 1'b0;
        repl     = 8'h00;
        for (int k = 0; k < hed_pkg::NumEnt; k++) begin
            hit[k] = cand_reg[k] && (held_cnt_reg < hed_pkg::ent_len(3'(k)))
                     && (hed_pkg::ent_char(3'(k), held_cnt_reg) == in_byte);
            complete[k] = hit[k] && ((held_cnt_reg + 3'd1) == hed_pkg::ent_len(3'(k)));
        end
        for (int k = hed_pkg::NumEnt - 1; k >= 0; k--) begin
            if (complete[k]) begin
                done_any = 1'b1;
                repl     = hed_pkg::ent_repl(3'(k));
            end
        end
        prefix_any = |(hit & ~complete);
    end

    // classify the item and work out the next entity state
    always_comb begin
        amp_open_next      = amp_open_reg;
        held_cnt_next      = held_cnt_reg;
        cand_next          = cand_reg;
        hold_wr            = 1'b0;
        q_entry            = '0;
        q_entry.held       = held_reg;
        q_entry.held_cnt   = held_cnt_reg;
        q_entry.last       = in_last;

        if (!amp_open_reg) begin
            if (in_byte == hed_pkg::ChAmp) begin
                amp_open_next = 1'b1;
                held_cnt_next = 3'd0;
                cand_next     = '1;
            end else begin
                q_entry.byte_val = in_byte;
                q_entry.extra_vld = 1'b1;
            end
        end else if (done_any) begin
            q_entry.byte_val  = repl;
            q_entry.extra_vld = 1'b1;
            amp_open_next     = 1'b0;
            held_cnt_next     = 3'd0;
        end else if (prefix_any) begin
            hold_wr       = 1'b1;
            held_cnt_next = held_cnt_reg + 3'd1;
            cand_next     = hit & ~complete;
        end else begin
            // broken entity: '&' plus held bytes, then the byte itself afresh
            q_entry.flush = 1'b1;
            if (in_byte == hed_pkg::ChAmp) begin
                amp_open_next = 1'b1;
                held_cnt_next = 3'd0;
                cand_next     = '1;
            end else begin
                q_entry.byte_val  = in_byte;
                q_entry.extra_vld = 1'b1;
                amp_open_next     = 1'b0;
                held_cnt_next     = 3'd0;
            end
        end

        // string end closes any entity still open
        if (in_last && amp_open_next) begin
            if (q_entry.flush) begin
                q_entry.byte_val  = hed_pkg::ChAmp;
                q_entry.extra_vld = 1'b1;
            end else if (hold_wr) begin
                q_entry.flush     = 1'b1;
                q_entry.byte_val  = in_byte;
                q_entry.extra_vld = 1'b1;
            end else begin
                q_entry.byte_val  = hed_pkg::ChAmp;
                q_entry.extra_vld = 1'b1;
            end
            amp_open_next = 1'b0;
            held_cnt_next = 3'd0;
        end

        emit = q_entry.flush || q_entry.extra_vld;
    end

    assign q_push = accept && emit;

    // entity state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_open_reg <= 1'b0;
            held_cnt_reg <= 3'd0;
            cand_reg     <= '0;
        end else if (accept) begin
            amp_open_reg <= amp_open_next;
            held_cnt_reg <= held_cnt_next;
            cand_reg     <= cand_next;
        end
    end

    // held bytes after the open '&'
    always_ff @(posedge aclk) begin
        for (int i = 0; i < hed_pkg::HeldMax; i++) begin
            if (accept && hold_wr && (held_cnt_reg == 3'(i))) begin
                held_reg[i] <= in_byte;
            end
        end
    end

    a_held_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg <= 3'(hed_pkg::HeldMax))
        else $error("held count beyond longest entity prefix");

    a_open_has_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        amp_open_reg |-> (cand_reg != '0))
        else $error("open entity with no candidate left");

    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last) |-> q_push)
        else $error("final byte of a string produced no item");

endmodule

[rtl/core/hed_fifo.sv]
// short queue of classified entries between front and back
module hed_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hed_pkg::entry_t  push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_vld,
    output hed_pkg::entry_t  head_entry
);

    localparam int CntW = $clog2(hed_pkg::FifoDepth + 1);

    hed_pkg::entry_t                 mem [hed_pkg::FifoDepth];
    logic [hed_pkg::FifoAw-1:0]      wr_ptr_reg;
    logic [hed_pkg::FifoAw-1:0]      rd_ptr_reg;
    logic [CntW-1:0]                 cnt_reg, cnt_next;

    assign full       = (cnt_reg == CntW'(hed_pkg::FifoDepth));
    assign head_vld   = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    // pointers and occupancy count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + hed_pkg::FifoAw'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + hed_pkg::FifoAw'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/core/hed_back.sv]
// back end: expands queue entries into output bytes behind an output register
module hed_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_vld,
    input  hed_pkg::entry_t  head_entry,
    output logic             pop,
    output logic             out_vld,
    input  logic             out_rdy,
    output logic [7:0]       out_byte,
    output logic             out_run_last,
    output logic             out_string_end
);

    logic [2:0]  idx_reg, idx_next;
    logic        vld_reg;
    logic [7:0]  byte_reg;
    logic        run_last_reg;
    logic        string_end_reg;

    logic [2:0]  total;
    logic [2:0]  held_idx;
    logic [7:0]  held_sel;
    logic [7:0]  cur_byte;
    logic        is_end;
    logic        load;

    // number of bytes this entry expands to
    assign total = head_entry.flush
                   ? (3'd1 + head_entry.held_cnt + {2'b00, head_entry.extra_vld})
                   : 3'd1;
    assign is_end   = (idx_reg == (total - 3'd1));
    assign held_idx = idx_reg - 3'd1;

    // pick the byte at the current position
    always_comb begin
        held_sel = 8'h00;
        for (int i = 0; i < hed_pkg::HeldMax; i++) begin
            if (held_idx == 3'(i)) begin
                held_sel = head_entry.held[i];
            end
        end
        if (!head_entry.flush) begin
            cur_byte = head_entry.byte_val;
        end else if (idx_reg == 3'd0) begin
            cur_byte = hed_pkg::ChAmp;
        end else if (idx_reg <= head_entry.held_cnt) begin
            cur_byte = held_sel;
        end else begin
            cur_byte = head_entry.byte_val;
        end
    end

    assign load     = head_vld && (!vld_reg || out_rdy);
    assign pop      = load && is_end;
    assign idx_next = is_end ? 3'd0 : (idx_reg + 3'd1);

    // control: position counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            vld_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= idx_next;
                vld_reg <= 1'b1;
            end else if (out_rdy) begin
                vld_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg       <= cur_byte;
            run_last_reg   <= is_end;
            string_end_reg <= is_end && head_entry.last;
        end
    end

    assign out_vld        = vld_reg;
    assign out_byte       = byte_reg;
    assign out_run_last   = run_last_reg;
    assign out_string_end = string_end_reg;

    a_idx_in_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        head_vld |-> (idx_reg < total))
        else $error("position counter ran past its entry");

    a_idle_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_vld |-> (idx_reg == 3'd0))
        else $error("position counter left mid entry with queue empty");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && !out_rdy) |=> (vld_reg && $stable(byte_reg)))
        else $error("output item changed while stalled");

endmodule

[rtl/core/html_entity_decoder_top.sv]
// top level of the streaming html entity decoder
//
//  channel | dir | tdata           | tuser        | tlast
//  s_      | in  | [7:0] in_byte   | -            | in_last
//  m_      | out | [7:0] out_byte  | [0] run_last | string_end
//
// the front takes one item per cycle while the four-entry queue has room
// each item yields 0 to 7 output bytes; the back sends one byte per cycle while
// the receiver is ready, and an item that yields no bytes puts nothing in the queue
// a broken entity flushes '&' plus up to five held bytes as one queue entry
// synchronous active-low reset clears entity state, queue and output valid
// output stalls back up through the queue into s_tready
module html_entity_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser,   // [0] run_last
    output logic        m_tlast
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             head_vld;
    hed_pkg::entry_t  push_entry;
    hed_pkg::entry_t  head_entry;

    // classify incoming items
    hed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .in_rdy   (s_tready),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // decoupling queue
    hed_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_vld   (head_vld),
        .head_entry (head_entry)
    );

    // expand entries into output bytes
    hed_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_vld       (head_vld),
        .head_entry     (head_entry),
        .pop            (q_pop),
        .out_vld        (m_tvalid),
        .out_rdy        (m_tready),
        .out_byte       (m_tdata),
        .out_run_last   (m_tuser),
        .out_string_end (m_tlast)
    );

endmodule

[test/html_entity_decoder_top_tb.sv]
// self-checking testbench for the streaming html entity decoder
`timescale 1ns / 1ps

module html_entity_decoder_top_tb;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 16;
    localparam int HoldCycles    = 250;

    // one decoded character as seen on the m_ channel
    typedef struct {
        logic [7:0] ch;
        logic       run_last;
        logic       str_end;
    } dec_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // entity bodies after the ampersand and the characters they stand for
    string      entity_body [8] = '{"amp;", "lt;", "gt;", "quot;", "#39;", "apos;",
                                    "ndash;", "mdash;"};
    logic [7:0] entity_char [8] = '{hed_pkg::ChAmp, hed_pkg::ChLt, hed_pkg::ChGt,
                                    hed_pkg::ChQuot, hed_pkg::ChApos, hed_pkg::ChApos,
                                    hed_pkg::ChDash, hed_pkg::ChDash};
    string      ent_alphabet = "amplgtquo#39sndh;&";

    // decoder state mirrored by the predictor
    logic [7:0]  ent_held [6];
    int unsigned ent_held_n = 0;
    bit          ent_open = 1'b0;
    logic [7:0]  step_chars [$];

    dec_char_t   decoded_chars [$];
    logic [7:0]  text_bytes [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  tx_idling = 1'b1;
    bit  rx_idling = 1'b1;
    int  hold_req = 0;
    int  stall_left = 0;

    html_entity_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] in_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] out_byte
        .m_tuser  (m_tuser),   // [0] run_last
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // byte outside an entity: an ampersand opens one, anything else passes
    function void take_plain(input logic [7:0] b);
        if (b == hed_pkg::ChAmp) begin
            ent_open = 1'b1;
            ent_held_n = 0;
        end else begin
            step_chars.push_back(b);
        end
    endfunction

    // give up on the open entity: ampersand plus held bytes as plain text
    function void flush_entity();
        int i;
        step_chars.push_back(hed_pkg::ChAmp);
        for (i = 0; i < ent_held_n; i++)
            step_chars.push_back(ent_held[i]);
        ent_open = 1'b0;
        ent_held_n = 0;
    endfunction

    // decode one input item and queue the characters it produces
    function void decode_byte(input logic [7:0] b, input logic last);
        bit         prefix;
        bit         hit;
        bit         same;
        logic [7:0] repl;
        int         k;
        int         i;
        int         len;
        prefix = 1'b0;
        hit = 1'b0;
        repl = 8'h00;
        step_chars.delete();
        if (!ent_open) begin
            take_plain(b);
        end else begin
            for (k = 0; k < 8 && !hit; k++) begin
                len = entity_body[k].len();
                if (ent_held_n < len) begin
                    same = 1'b1;
                    for (i = 0; i < ent_held_n; i++)
                        if (entity_body[k][i] != ent_held[i])
                            same = 1'b0;
                    if (same && entity_body[k][ent_held_n] == b) begin
                        if (ent_held_n + 1 == len) begin
                            hit = 1'b1;
                            repl = entity_char[k];
                        end else begin
                            prefix = 1'b1;
                        end
                    end
                end
            end
            if (hit) begin
                step_chars.push_back(repl);
                ent_open = 1'b0;
                ent_held_n = 0;
            end else if (prefix) begin
                ent_held[ent_held_n] = b;
                ent_held_n++;
            end else begin
                flush_entity();
                take_plain(b);
            end
        end
        // end of string closes any unfinished entity
        if (last && ent_open)
            flush_entity();
        for (i = 0; i < step_chars.size(); i++)
            decoded_chars.push_back('{ch: step_chars[i],
                                      run_last: (i == step_chars.size() - 1),
                                      str_end: last && (i == step_chars.size() - 1)});
    endfunction

    // random text made of entities, partial and broken entities and plain bytes
    function void build_text(input int pieces);
        int p;
        int k;
        int j;
        int cut;
        int kind;
        text_bytes.delete();
        for (p = 0; p < pieces; p++) begin
            k = $urandom_range(0, 7);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    text_bytes.push_back(8'($urandom_range(1, 255)));
                end
                3, 4, 5: begin
                    text_bytes.push_back(hed_pkg::ChAmp);
                    for (j = 0; j < entity_body[k].len(); j++)
                        text_bytes.push_back(entity_body[k][j]);
                end
                6, 7: begin
                    cut = $urandom_range(0, entity_body[k].len() - 1);
                    text_bytes.push_back(hed_pkg::ChAmp);
                    for (j = 0; j < cut; j++)
                        text_bytes.push_back(entity_body[k][j]);
                    if (kind == 7)
                        text_bytes.push_back(8'($urandom_range(1, 255)));
                end
                8: begin
                    text_bytes.push_back(hed_pkg::ChAmp);
                end
                default: begin
                    text_bytes.push_back(ent_alphabet[$urandom_range(0, ent_alphabet.len() - 1)]);
                end
            endcase
        end
    endfunction

    // offer one item; entered at a falling edge, returns at the falling edge after
    // acceptance with valid still high, so the caller sends again or drops valid
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        do
            @(posedge aclk);
        while (!s_tready);
        decode_byte(b, last);
        items_sent++;
        @(negedge aclk);
    endtask

    // send the text buffer as one string
    task automatic send_text();
        int i;
        for (i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic send_literal(input string s);
        int i;
        text_bytes.delete();
        for (i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
        send_text();
    endtask

    // byte extremes, bare ampersand, broken and unfinished entities
    task automatic test_directed();
        text_bytes = '{8'h01, hed_pkg::ChAmp, 8'hFF};
        send_text();
        send_literal("&");
        send_literal("&nda&lt;");
        send_literal("&mdashX");
        send_literal("&quo");
        send_literal("&amp;");
    endtask

    // random strings, idling switched per string
    task automatic test_random_strings();
        while (items_sent < 330) begin
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
            build_text($urandom_range(1, 8));
            send_text();
        end
    endtask

    // receiver holds off while long flushes keep coming, so the input stalls
    task automatic test_output_hold();
        int r;
        tx_idling = 1'b0;
        rx_idling = 1'b1;
        hold_req = HoldCycles;
        text_bytes.delete();
        for (r = 0; r < 6; r++) begin
            text_bytes.push_back(hed_pkg::ChAmp);
            text_bytes.push_back("m");
            text_bytes.push_back("d");
            text_bytes.push_back("a");
            text_bytes.push_back("s");
            text_bytes.push_back("h");
            text_bytes.push_back(8'($urandom_range(1, 255)));
        end
        send_text();
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        while (items_sent < 420) begin
            build_text($urandom_range(1, 8));
            send_text();
        end
    endtask

    // receiver: random stall bursts plus requested long hold-off
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end else if (stall_left == 0 && rx_idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7);
        end
        if (stall_left != 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
        end
    end

    // compare each output item with the oldest predicted character
    always @(posedge aclk) begin : check_output
        dec_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_chars.size() == 0) begin
                $error("unexpected output item: out_byte %02h", m_tdata);
                fail_count++;
            end else begin
                want = decoded_chars.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("out_byte mismatch: expected %02h, actual %02h", want.ch, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.run_last) begin
                    $error("run_last mismatch: expected %0b, actual %0b",
                           want.run_last, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== want.str_end) begin
                    $error("string_end mismatch: expected %0b, actual %0b",
                           want.str_end, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $error("no item moved for %0d cycles", WatchdogLimit);
                $display("html_entity_decoder_top_tb failed");
                $finish;
            end
        end
    end

    // reset, test sequence and final verdict
    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random_strings();
        test_output_hold();
        test_steady_stream();
        s_tvalid = 1'b0;
        while (decoded_chars.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0)
            $display("html_entity_decoder_top_tb passed");
        else
            $display("html_entity_decoder_top_tb failed");
        $finish;
    end

endmodule

[html_entity_decoder_top.f]
rtl/core/hed_pkg.sv
rtl/core/hed_front.sv
rtl/core/hed_fifo.sv
rtl/core/hed_back.sv
rtl/core/html_entity_decoder_top.sv
test/html_entity_decoder_top_tb.sv
